// ----- rtl/bba_pkg.sv -----
// Shared constants, codes, types and a helper function of the block bitmap allocator.
package bba_pkg;

  localparam int BLOCKS  = 1024;
  localparam int MAX_RUN = 16;

  localparam int WORD_W = 32;
  localparam int WORDS  = BLOCKS / WORD_W;
  localparam int BIT_W  = $clog2(WORD_W);
  localparam int ROW_W  = $clog2(WORDS);
  localparam int BLK_W  = ROW_W + BIT_W;
  localparam int CNT_W  = $clog2(BLOCKS + 1);
  localparam int RUN_W  = $clog2(MAX_RUN + 1);

  localparam int OP_W  = 1;
  localparam int REQ_W = 5;
  localparam int IDX_W = 10;
  localparam int ST_W  = 2;

  localparam logic [OP_W-1:0] OP_ALLOC = 1'b0;
  localparam logic [OP_W-1:0] OP_FREE  = 1'b1;

  localparam logic [ST_W-1:0] ST_OK           = 2'd0;
  localparam logic [ST_W-1:0] ST_NOSPACE      = 2'd1;
  localparam logic [ST_W-1:0] ST_ALREADY_FREE = 2'd2;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [ROW_W-1:0]  row_t;
  typedef logic [BIT_W-1:0]  bit_pos_t;

  // Priority encoder: position of the lowest clear bit of a bitmap word.
  function automatic bit_pos_t lowest_zero(input word_t w);
    bit_pos_t pos;
    pos = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (!w[i]) pos = BIT_W'(i);
    end
    return pos;
  endfunction

endpackage

// ----- rtl/bba_bitmap.sv -----
// Used/free bitmap storage: one word per row, with per-row valid bits that reset clears.
module bba_bitmap (
  input  logic          clk,
  input  logic          rst,
  input  bba_pkg::row_t  rd_addr,
  output bba_pkg::word_t rd_data,
  input  logic          wr_en,
  input  bba_pkg::row_t  wr_addr,
  input  bba_pkg::word_t wr_data
);
  import bba_pkg::*;

  word_t             mem [WORDS];
  logic [WORDS-1:0]  row_valid;
  word_t             mem_q;
  logic              vld_q;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    mem_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      vld_q     <= 1'b0;
    end else begin
      if (wr_en) begin
        row_valid[wr_addr] <= 1'b1;
      end
      vld_q <= row_valid[rd_addr];
    end
  end

  // A row never written since reset reads as all free.
  assign rd_data = vld_q ? mem_q : '0;

endmodule

// ----- rtl/block_bitmap_allocator_core.sv -----
// Top level of the block bitmap allocator: request sequencer, word scanner and result register.
// Free request: the free-check state registers the result once the result register is free.
// Allocate request: the first grant is registered after the load and scan states, then one
// grant per cycle while the result register is free; each full word crossed costs a memory read.
// A failed allocate gives its single result from the refusal state.
// Reset clears the bitmap (all blocks free) through per-row valid bits.
module block_bitmap_allocator_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [bba_pkg::OP_W-1:0]   opcode,
  input  logic [bba_pkg::REQ_W-1:0]  request_count,
  input  logic [bba_pkg::IDX_W-1:0]  free_index,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [bba_pkg::IDX_W-1:0]  allocated_index,
  output logic [bba_pkg::ST_W-1:0]   status,
  output logic                       last_result
);
  import bba_pkg::*;

  // The sequencer takes one request at a time. Allocation walks the bitmap
  // word by word from a hint row, below which every word is known to be full,
  // and a single priority encoder picks the lowest free block of the word held
  // in cur_word, one grant per cycle while the result register is free.
  typedef enum logic [2:0] {
    S_IDLE,
    S_FREE_CHK,
    S_FAIL,
    S_ALLOC_LOAD,
    S_ALLOC_SCAN
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] free_total;
  row_t             hint;
  row_t             cur_row;
  word_t            cur_word;
  logic [RUN_W-1:0] remaining;
  row_t             free_row;
  bit_pos_t         free_bit;
  logic             free_in_pool;

  logic             in_xfer;
  logic             out_free;
  logic             out_load;
  logic [RUN_W-1:0] want;
  logic [BLK_W-1:0] req_blk;
  logic             req_in_pool;
  row_t             rd_addr;
  word_t            rd_data;
  logic             wr_en;
  row_t             wr_addr;
  word_t            wr_data;
  bit_pos_t         zero_pos;
  logic             word_full;
  logic             grant;
  logic             free_hit;

  assign in_stall = (state != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  // The result register can take a new result when it is empty or being drained.
  assign out_free = !out_valid || !out_stall;

  // A zero count is read as one block and anything above the run limit saturates.
  always_comb begin
    if (request_count == '0) begin
      want = RUN_W'(1);
    end else if (32'(request_count) > MAX_RUN) begin
      want = RUN_W'(MAX_RUN);
    end else begin
      want = RUN_W'(request_count);
    end
  end

  assign req_blk     = BLK_W'(free_index);
  assign req_in_pool = 32'(free_index) < BLOCKS;

  assign zero_pos  = lowest_zero(cur_word);
  assign word_full = &cur_word;
  assign grant     = (state == S_ALLOC_SCAN) && !word_full && out_free;
  assign free_hit  = free_in_pool && rd_data[free_bit];

  // A result is loaded by a free check, a refusal or a grant once the register is free.
  assign out_load = ((state == S_FREE_CHK || state == S_FAIL) && out_free) || grant;

  // Bitmap read address: the freed block's row on a free transfer and while its
  // result waits, the hint row when an allocation starts, and the following row
  // when a full word is left.
  always_comb begin
    rd_addr = hint;
    if (state == S_IDLE && opcode == OP_FREE) begin
      rd_addr = req_blk[BLK_W-1:BIT_W];
    end else if (state == S_FREE_CHK) begin
      rd_addr = free_row;
    end else if (state == S_ALLOC_SCAN) begin
      rd_addr = cur_row + ROW_W'(1);
    end
  end

  // Bitmap write port: a word is written back when the scan leaves it or when
  // the last block of the run is granted, and on a free that hits a used block.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cur_row;
    wr_data = cur_word;
    if (state == S_ALLOC_SCAN) begin
      if (word_full) begin
        wr_en = 1'b1;
      end else if (grant && remaining == RUN_W'(1)) begin
        wr_en            = 1'b1;
        wr_data[zero_pos] = 1'b1;
      end
    end else if (state == S_FREE_CHK && out_free && free_hit) begin
      wr_en            = 1'b1;
      wr_addr          = free_row;
      wr_data          = rd_data;
      wr_data[free_bit] = 1'b0;
    end
  end

  bba_bitmap u_bitmap (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      free_total <= CNT_W'(BLOCKS);
      hint       <= '0;
      out_valid  <= 1'b0;
    end else begin
      out_valid <= out_load || (out_valid && out_stall);
      unique case (state)
        S_IDLE: begin
          if (in_xfer) begin
            if (opcode == OP_FREE) begin
              free_row     <= req_blk[BLK_W-1:BIT_W];
              free_bit     <= req_blk[BIT_W-1:0];
              free_in_pool <= req_in_pool;
              state        <= S_FREE_CHK;
            end else if (free_total < CNT_W'(want)) begin
              state <= S_FAIL;
            end else begin
              remaining <= want;
              cur_row   <= hint;
              state     <= S_ALLOC_LOAD;
            end
          end
        end
        S_FREE_CHK: begin
          if (out_free) begin
            allocated_index <= '0;
            last_result     <= 1'b1;
            if (free_hit) begin
              status <= ST_OK;
              if (free_total < CNT_W'(BLOCKS)) begin
                free_total <= free_total + CNT_W'(1);
              end
              if (free_row < hint) begin
                hint <= free_row;
              end
            end else begin
              status <= ST_ALREADY_FREE;
            end
            state <= S_IDLE;
          end
        end
        S_FAIL: begin
          if (out_free) begin
            allocated_index <= '0;
            status          <= ST_NOSPACE;
            last_result     <= 1'b1;
            state           <= S_IDLE;
          end
        end
        S_ALLOC_LOAD: begin
          cur_word <= rd_data;
          state    <= S_ALLOC_SCAN;
        end
        S_ALLOC_SCAN: begin
          if (word_full) begin
            // Every row up to this one is now full, so later scans skip it.
            cur_row <= cur_row + ROW_W'(1);
            hint    <= cur_row + ROW_W'(1);
            state   <= S_ALLOC_LOAD;
          end else if (grant) begin
            allocated_index     <= IDX_W'({cur_row, zero_pos});
            status              <= ST_OK;
            last_result         <= (remaining == RUN_W'(1));
            cur_word[zero_pos]  <= 1'b1;
            remaining           <= remaining - RUN_W'(1);
            free_total          <= free_total - CNT_W'(1);
            if (remaining == RUN_W'(1)) begin
              hint  <= cur_row;
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  // The free count can never exceed the size of the pool.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    free_total <= CNT_W'(BLOCKS))
    else $error("free block count above pool size");

  // Results other than a grant carry index zero and end their request.
  a_fail_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> last_result && allocated_index == '0)
    else $error("non-success result with index or without last marker");

  // Every granted block lowers the free count by exactly one.
  a_grant_count: assert property (@(posedge clk) disable iff (rst)
    grant |=> free_total == $past(free_total) - CNT_W'(1))
    else $error("grant did not lower the free count");

  // The bitmap is only written while a request is being worked on.
  a_no_idle_write: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> state != S_IDLE)
    else $error("bitmap write while idle");

  // A new result only enters the result register when it is free.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(allocated_index) && $stable(status))
    else $error("pending result overwritten");
`endif

endmodule
